// ----- design/multimode_iq_demodulator_macros.svh -----
// Assertion macros shared by the demodulator modules.
`ifndef MULTIMODE_IQ_DEMODULATOR_MACROS_SVH
`define MULTIMODE_IQ_DEMODULATOR_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define MIQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define MIQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/miqd_pkg.sv -----
// ----------------------------------------------------------------------------
// miqd_pkg
// Shared constants, types and tables for the multimode I/Q demodulator.
// ----------------------------------------------------------------------------
`default_nettype none
package miqd_pkg;
    localparam int SW       = 16;
    localparam int FRAC     = SW - 1;
    localparam int NSTAGES  = 16;
    localparam int GUARD    = 8;
    localparam int CW_W     = SW + GUARD + 3;
    localparam int STG_W    = $clog2(NSTAGES + 1);
    localparam int ACC_W    = 48;

    // Reciprocal of 255 with 16 extra fraction bits; exact for every byte.
    localparam longint CTR_RECIP = ((longint'(1) << (FRAC + 16)) + 254) / 255;
    localparam int     CTR_RW    = FRAC + 9;

    localparam logic [2:0] MODE_NFM = 3'd0;
    localparam logic [2:0] MODE_WFM = 3'd1;
    localparam logic [2:0] MODE_AM  = 3'd2;
    localparam logic [2:0] MODE_USB = 3'd3;
    localparam logic [2:0] MODE_LSB = 3'd4;
    localparam logic [2:0] MODE_CW  = 3'd5;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_RATIO  = 3'd1;
    localparam logic [2:0] REG_PRE    = 3'd2;
    localparam logic [2:0] REG_POST   = 3'd3;
    localparam logic [2:0] REG_DEEMPH = 3'd4;

    typedef logic signed [SW-1:0] samp_t;

    typedef struct packed {
        logic         start;
        logic [SW-1:0] i_c;
        logic [SW-1:0] q_c;
    } cordic_req_t;

    typedef struct packed {
        logic          done;
        logic [SW-1:0] angle;
        logic signed [SW+1:0] mag;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] k);
        logic [31:0] r;
        case (k)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Offset-binary byte to signed sample: (2b-255)*2^FRAC/255, toward zero.
    function automatic samp_t centre(input logic [7:0] b);
        logic signed [9:0]  t;
        logic [8:0]         m;
        logic [CTR_RW+8:0]  p;
        logic [SW-1:0]      quo;
        logic signed [SW:0] v;
        t = $signed({1'b0, b, 1'b0}) - 10'sd255;
        m = t[9] ? 9'(-t) : t[8:0];
        // Divide by 255 through the reciprocal, then drop the extra bits.
        p = (CTR_RW+9)'(m) * (CTR_RW+9)'(CTR_RECIP);
        quo = p[16 +: SW];
        v = t[9] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        if (v > $signed((SW+1)'((1 << FRAC) - 1))) v = (SW+1)'((1 << FRAC) - 1);
        return v[SW-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- design/miqd_cordic.sv -----
// ----------------------------------------------------------------------------
// miqd_cordic
// Iterative vectoring CORDIC: one rotation per cycle, angle and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none
module miqd_cordic (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  miqd_pkg::cordic_req_t      req,
    output miqd_pkg::cordic_rsp_t      rsp
);
    import miqd_pkg::*;

    logic signed [CW_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [31:0]            z_reg, z_next;
    logic [STG_W-1:0]       k_reg, k_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic signed [SW+1:0]   mag_reg, mag_next;
    logic [SW-1:0]          ang_reg, ang_next;
    logic signed [CW_W-1:0] dx, dy, xi, yi;
    logic signed [CW_W+16:0] prod;

    // Floor shift of a magnitude toward minus infinity on negatives equals
    // arithmetic shift when rounded up in magnitude; mirror floor_shr exactly.
    function automatic logic signed [CW_W-1:0] fsh(input logic signed [CW_W-1:0] v,
                                                   input logic [STG_W-1:0] s);
        logic [CW_W-1:0] m;
        logic [CW_W-1:0] one;
        if (!v[CW_W-1]) return v >>> s;
        one = {{(CW_W-1){1'b0}}, 1'b1};
        m = CW_W'(-v);
        m = (m + ((one << s) - one)) >> s;
        return -$signed(m);
    endfunction

    always_comb begin
        xi = $signed({{(CW_W-SW){req.i_c[SW-1]}}, req.i_c}) <<< GUARD;
        yi = $signed({{(CW_W-SW){req.q_c[SW-1]}}, req.q_c}) <<< GUARD;
        dx = fsh(y_reg, k_reg);
        dy = fsh(x_reg, k_reg);
        prod = x_reg * $signed(18'sd39797);
        x_next = x_reg; y_next = y_reg; z_next = z_reg; k_next = k_reg;
        busy_next = busy_reg; done_next = 1'b0;
        mag_next = mag_reg; ang_next = ang_reg;
        if (req.start) begin
            if (xi < 0) begin
                x_next = -xi; y_next = -yi; z_next = 32'h8000_0000;
            end else begin
                x_next = xi; y_next = yi; z_next = '0;
            end
            k_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (k_reg == STG_W'(NSTAGES)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                ang_next = z_reg[31 -: SW];
                mag_next = (SW+2)'(prod >>> (16 + GUARD));
            end else begin
                if (y_reg > 0) begin
                    x_next = x_reg + dx; y_next = y_reg - dy;
                    z_next = z_reg + atan_entry(5'(k_reg));
                end else begin
                    x_next = x_reg - dx; y_next = y_reg + dy;
                    z_next = z_reg - atan_entry(5'(k_reg));
                end
                k_next = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        mag_reg <= mag_next; ang_reg <= ang_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.angle = ang_reg;
    assign rsp.mag   = mag_reg;

    `include "multimode_iq_demodulator_macros.svh"
    `MIQ_ASSERT_NXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg, "done held")
    `MIQ_ASSERT_IMP(a_k_range, aclk, aresetn, busy_reg, k_reg <= STG_W'(NSTAGES), "k range")
    `MIQ_ASSERT_NXT(a_start_busy, aclk, aresetn, req.start, busy_reg, "start lost")
endmodule
`default_nettype wire

// ----- design/multimode_iq_demodulator.sv -----
// ----------------------------------------------------------------------------
// multimode_iq_demodulator
// FM/AM/SSB/CW detector with linear-interpolating decimator and filters.
// ----------------------------------------------------------------------------
// Usage: feed one I/Q byte pair per s_axis beat (tdata = {q_byte, i_byte}).
// The block runs one sample at a time: after a beat it drops s_axis_tready
// until the CORDIC and the filter sequencer finish. The CORDIC runs through
// launch, load, 16 rotations, scale and hand-off; each filter or interpolator
// step then multiplies on the single shared multiplier and registers the
// product before it updates its state. FM modes add the smoothing and
// pre-filter steps; an emitted result adds the de-emphasis step (WFM only),
// the post-filter step and the output step.
// An input beat yields zero or one m_axis beat (audio_sample, Q1.15).
// A result is held in the output register until m_axis_tready; the next input
// is still taken and processed, and holds in its last step while a result
// still waits there.
// Configuration must be written by the user via cfg_we/cfg_addr/cfg_wdata
// only while idle, unenforced by the block; a new mode clears detector and
// filter state. Reset (aresetn low, synchronous) restores register defaults
// (WFM mode, ratio 42.67) and clears all filter and interpolator state.
`default_nettype none
module multimode_iq_demodulator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [7:0] i_byte, [15:8] q_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] audio_sample
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_addr,
    input  wire  [23:0] cfg_wdata
);
    import miqd_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CORD   = 4'd1;
    localparam logic [3:0] ST_DET    = 4'd2;
    localparam logic [3:0] ST_SMOOTH = 4'd3;
    localparam logic [3:0] ST_PRE    = 4'd4;
    localparam logic [3:0] ST_PRE2   = 4'd5;
    localparam logic [3:0] ST_RS     = 4'd6;
    localparam logic [3:0] ST_RS2    = 4'd7;
    localparam logic [3:0] ST_DE     = 4'd8;
    localparam logic [3:0] ST_DE2    = 4'd9;
    localparam logic [3:0] ST_POST   = 4'd10;
    localparam logic [3:0] ST_POST2  = 4'd11;
    localparam logic [3:0] ST_OUT    = 4'd12;

    localparam logic signed [SW+1:0] TOP = (SW+2)'((1 << FRAC) - 1);

    logic [3:0]  st_reg, st_next;
    logic [2:0]  mode_reg;
    logic [23:0] ratio_reg;
    logic [15:0] pre_a_reg, post_a_reg, de_a_reg;
    logic [SW-1:0] prev_ang_reg;
    logic        seen_reg;
    logic signed [SW+1:0] smooth_reg;
    logic signed [ACC_W-1:0] pre_reg, de_reg, post_reg;
    logic signed [SW+1:0] rprev_reg;
    logic        rseen_reg;
    logic [24:0] rphase_reg;
    logic signed [SW-1:0] i_reg, q_reg;
    logic signed [SW+1:0] x_reg, d_reg;
    logic signed [ACC_W-1:0] diff_reg;
    logic signed [ACC_W+17:0] prod_reg;
    logic        valid_reg;
    logic [15:0] out_reg;
    logic        start_reg;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    // Shared multiplier operands.
    logic signed [ACC_W-1:0] mul_a;
    logic signed [17:0]      mul_b;
    logic signed [ACC_W+17:0] mul_p;

    function automatic logic signed [ACC_W+17:0] fsh16(input logic signed [ACC_W+17:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] acc);
        return (acc + ACC_W'(32768)) >>> 16;
    endfunction

    assign creq.start = start_reg;
    assign creq.i_c   = i_reg;
    assign creq.q_c   = q_reg;

    miqd_cordic u_cordic (.aclk(aclk), .aresetn(aresetn), .req(creq), .rsp(crsp));

    always_comb begin
        mul_a = '0; mul_b = '0;
        case (st_reg)
            ST_PRE:  begin mul_a = diff_reg; mul_b = $signed({2'b00, pre_a_reg}); end
            ST_RS:   begin mul_a = diff_reg; mul_b = $signed({1'b0, rphase_reg[16:0]}); end
            ST_DE:   begin mul_a = diff_reg; mul_b = $signed({2'b00, de_a_reg}); end
            ST_POST: begin mul_a = diff_reg; mul_b = $signed({2'b00, post_a_reg}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
    end

    logic signed [SW+1:0] d_w, det_x, mag_c;
    logic signed [SW+1:0] am_x;
    logic signed [SW+1:0] ssb;
    logic [SW-1:0] dang;
    logic signed [40:0] nfm;
    logic [24:0] ratio_e;

    always_comb begin
        dang = crsp.angle - prev_ang_reg;
        d_w  = seen_reg ? (SW+2)'($signed(dang)) : '0;
        mag_c = crsp.mag > TOP ? TOP : crsp.mag;
        am_x = crsp.mag - (SW+2)'(1 << (FRAC - 1));
        if (am_x > TOP) am_x = TOP;
        ssb = (mode_reg == MODE_USB) ? ((SW+2)'(i_reg) + (SW+2)'(q_reg)) >>> 1
                                     : ((SW+2)'(i_reg) - (SW+2)'(q_reg)) >>> 1;
        case (mode_reg)
            MODE_AM:  det_x = am_x;
            MODE_CW:  det_x = mag_c;
            MODE_USB, MODE_LSB: det_x = ssb;
            default:  det_x = '0;
        endcase
        nfm = 41'sd45875 * 41'(smooth_reg) + 41'sd19661 * 41'(d_reg) + 41'sd32768;
        ratio_e = (ratio_reg < 24'd65536) ? 25'd65536 : {1'b0, ratio_reg};
    end

    logic signed [ACC_W+17:0] pnew;
    logic signed [SW+1:0] yo;
    logic signed [ACC_W-1:0] yfin;
    always_comb begin
        pnew = fsh16(prod_reg);
        yfin = rnd(post_reg);
        yo = (yfin > ACC_W'(32767)) ? (SW+2)'(32767) :
             (yfin < -ACC_W'(32768)) ? -(SW+2)'(32768) : yfin[SW+1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; start_reg <= 1'b0; valid_reg <= 1'b0;
            mode_reg <= MODE_WFM; ratio_reg <= 24'd2796203;
            pre_a_reg <= 16'd800; post_a_reg <= 16'd10923; de_a_reg <= 16'd2897;
            prev_ang_reg <= '0; seen_reg <= 1'b0; smooth_reg <= '0;
            pre_reg <= '0; de_reg <= '0; post_reg <= '0;
            rprev_reg <= '0; rseen_reg <= 1'b0; rphase_reg <= '0;
        end else begin
            start_reg <= 1'b0;
            // Free the output register; the last step refills it itself.
            if (valid_reg && m_axis_tready && st_reg != ST_OUT) valid_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MODE: if (cfg_wdata[2:0] != mode_reg) begin
                        mode_reg <= cfg_wdata[2:0];
                        prev_ang_reg <= '0; seen_reg <= 1'b0; smooth_reg <= '0;
                        pre_reg <= '0; de_reg <= '0; post_reg <= '0;
                    end
                    REG_RATIO:  ratio_reg <= cfg_wdata;
                    REG_PRE:    pre_a_reg <= cfg_wdata[15:0];
                    REG_POST:   post_a_reg <= cfg_wdata[15:0];
                    REG_DEEMPH: de_a_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            case (st_reg)
                ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    i_reg <= centre(s_axis_tdata[7:0]);
                    q_reg <= centre(s_axis_tdata[15:8]);
                    start_reg <= 1'b1;
                    st_reg <= ST_CORD;
                end
                ST_CORD: if (crsp.done) begin
                    d_reg <= d_w;
                    x_reg <= det_x;
                    if (mode_reg == MODE_NFM || mode_reg == MODE_WFM) begin
                        prev_ang_reg <= crsp.angle;
                        seen_reg <= 1'b1;
                        st_reg <= ST_SMOOTH;
                    end else st_reg <= ST_RS;
                    diff_reg <= ACC_W'(det_x) - ACC_W'(rprev_reg);
                end
                ST_SMOOTH: begin
                    if (mode_reg == MODE_NFM) begin
                        smooth_reg <= (SW+2)'(nfm >>> 16);
                        diff_reg <= (ACC_W'((SW+2)'(nfm >>> 16)) <<< 16) - pre_reg;
                    end else begin
                        smooth_reg <= (smooth_reg + d_reg + (SW+2)'(1)) >>> 1;
                        diff_reg <= (ACC_W'((smooth_reg + d_reg + (SW+2)'(1)) >>> 1) <<< 16)
                                    - pre_reg;
                    end
                    st_reg <= ST_PRE;
                end
                ST_PRE: begin prod_reg <= mul_p; st_reg <= ST_PRE2; end
                ST_PRE2: begin
                    pre_reg <= pre_reg + ACC_W'(pnew);
                    x_reg <= (SW+2)'(rnd(pre_reg + ACC_W'(pnew)));
                    diff_reg <= ACC_W'(rnd(pre_reg + ACC_W'(pnew))) - ACC_W'(rprev_reg);
                    st_reg <= ST_RS;
                end
                ST_RS: begin prod_reg <= mul_p; st_reg <= ST_RS2; end
                ST_RS2: begin
                    rprev_reg <= x_reg;
                    st_reg <= ST_IDLE;
                    if (!rseen_reg) rseen_reg <= 1'b1;
                    else if (rphase_reg < 25'd65536) begin
                        rphase_reg <= rphase_reg + ratio_e - 25'd65536;
                        if (mode_reg == MODE_WFM) begin
                            diff_reg <= (ACC_W'(rprev_reg + (SW+2)'(pnew)) <<< 16) - de_reg;
                            st_reg <= ST_DE;
                        end else begin
                            diff_reg <= (ACC_W'(rprev_reg + (SW+2)'(pnew)) <<< 16) - post_reg;
                            st_reg <= ST_POST;
                        end
                    end else rphase_reg <= rphase_reg - 25'd65536;
                end
                ST_DE: begin prod_reg <= mul_p; st_reg <= ST_DE2; end
                ST_DE2: begin
                    de_reg <= de_reg + ACC_W'(pnew);
                    diff_reg <= (rnd(de_reg + ACC_W'(pnew)) <<< 16) - post_reg;
                    st_reg <= ST_POST;
                end
                ST_POST: begin prod_reg <= mul_p; st_reg <= ST_POST2; end
                ST_POST2: begin
                    post_reg <= post_reg + ACC_W'(pnew);
                    st_reg <= ST_OUT;
                end
                // Hold here while the previous result still waits.
                ST_OUT: if (!valid_reg || m_axis_tready) begin
                    out_reg <= yo[15:0];
                    valid_reg <= 1'b1;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = out_reg;

    `include "multimode_iq_demodulator_macros.svh"
    `MIQ_ASSERT_IMP(a_no_take_busy, aclk, aresetn, st_reg != ST_IDLE, !s_axis_tready, "ready busy")
    `MIQ_ASSERT_NXT(a_out_hold, aclk, aresetn, valid_reg && !m_axis_tready,
                    valid_reg && $stable(out_reg), "result dropped")
    `MIQ_ASSERT_NXT(a_start_cord, aclk, aresetn, s_axis_tvalid && s_axis_tready,
                    st_reg == ST_CORD, "no cordic start")
endmodule
`default_nettype wire

// ----- tb/sv/multimode_iq_demodulator_tb.sv -----
// ----------------------------------------------------------------------------
// multimode_iq_demodulator_tb
// Self-checking bench: a bit-exact predictor of the detector, interpolator and
// filters runs beside the block; every audio beat is checked against it.
// ----------------------------------------------------------------------------
`default_nettype none
module multimode_iq_demodulator_tb;
    import miqd_pkg::*;

    localparam int WD_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;
    localparam longint ONE_Q16 = 65536;

    // Mode codes with no detector, and register indexes with no register.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [2:0] REG_SPARE_LO  = 3'd5;
    localparam logic [2:0] REG_SPARE_HI  = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [15:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;

    multimode_iq_demodulator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Predictor state: registers and the detector / filter chain.
    logic [2:0]  cur_mode;
    logic [23:0] cur_ratio;
    logic [15:0] cur_pre, cur_post, cur_deemph;
    logic [15:0] last_angle;
    bit          angle_valid;
    longint      smooth_acc, pre_acc, deemph_acc, post_acc;
    longint      interp_prev;
    bit          interp_valid;
    logic [24:0] interp_phase;

    logic [15:0] audio_q[$];
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          idle_cycles = 0;
    int          mode_hits[8];

    function automatic longint floor_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint centre_byte(logic [7:0] b);
        longint v;
        v = ((longint'(b) * 2 - 255) * (longint'(1) << FRAC)) / 255;
        return (v > (longint'(1) << FRAC) - 1) ? (longint'(1) << FRAC) - 1 : v;
    endfunction

    function automatic longint one_pole(inout longint acc, input logic [15:0] a,
                                        input longint x);
        acc += floor_shr(longint'(a) * (x * ONE_Q16 - acc), 16);
        return floor_shr(acc + 32768, 16);
    endfunction

    function automatic longint atan_step(int k);
        longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                          21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                          333772, 166886, 83443, 41722, 20861};
        return t[k];
    endfunction

    task automatic vector_mode(input longint ii, input longint qq,
                               output logic [15:0] ang, output longint mag);
        logic [31:0] z;
        longint      di, dq;
        z = 32'd0;
        ii = ii * 256;
        qq = qq * 256;
        if (ii < 0) begin
            ii = -ii; qq = -qq; z = 32'h8000_0000;
        end
        for (int k = 0; k < NSTAGES; k++) begin
            di = floor_shr(qq, k);
            dq = floor_shr(ii, k);
            if (qq > 0) begin
                ii += di; qq -= dq; z += 32'(atan_step(k));
            end else begin
                ii -= di; qq += dq; z -= 32'(atan_step(k));
            end
        end
        ang = z[31:16];
        mag = floor_shr(ii * 39797, 24);
    endtask

    task automatic clear_chain();
        last_angle = '0; angle_valid = 0; smooth_acc = 0;
        pre_acc = 0; deemph_acc = 0; post_acc = 0;
    endtask

    task automatic predict_reset();
        cur_mode = MODE_WFM; cur_ratio = 24'd2796203; cur_pre = 16'd800;
        cur_post = 16'd10923; cur_deemph = 16'd2897;
        clear_chain();
        interp_prev = 0; interp_valid = 0; interp_phase = '0;
    endtask

    // Work out the audio beat (if any) caused by one I/Q beat.
    task automatic predict_audio(input logic [7:0] ib, input logic [7:0] qb);
        longint      ic, qc, mag, x, y, d, top, ratio;
        logic [15:0] ang;
        bit          emit;
        top = (longint'(1) << FRAC) - 1;
        ic = centre_byte(ib);
        qc = centre_byte(qb);
        x = 0;
        emit = 0;
        vector_mode(ic, qc, ang, mag);
        mode_hits[cur_mode]++;
        case (cur_mode)
            MODE_NFM, MODE_WFM: begin
                d = 0;
                if (angle_valid) begin
                    d = longint'(16'(ang - last_angle));
                    if (d >= 32768) d -= 65536;
                end
                last_angle = ang;
                angle_valid = 1;
                if (cur_mode == MODE_NFM)
                    smooth_acc = floor_shr(45875 * smooth_acc + 19661 * d + 32768, 16);
                else
                    smooth_acc = floor_shr(smooth_acc + d + 1, 1);
                x = one_pole(pre_acc, cur_pre, smooth_acc);
            end
            MODE_AM: begin
                x = mag - (longint'(1) << (FRAC - 1));
                if (x > top) x = top;
            end
            MODE_USB: x = floor_shr(ic + qc, 1);
            MODE_LSB: x = floor_shr(ic - qc, 1);
            MODE_CW:  x = (mag > top) ? top : mag;
            default:  x = 0;
        endcase
        ratio = (cur_ratio < ONE_Q16) ? ONE_Q16 : longint'(cur_ratio);
        y = 0;
        if (!interp_valid) begin
            interp_valid = 1;
        end else begin
            if (interp_phase < ONE_Q16) begin
                y = interp_prev + floor_shr(longint'(interp_phase) * (x - interp_prev), 16);
                interp_phase = 25'(longint'(interp_phase) + ratio);
                emit = 1;
            end
            interp_phase = 25'(longint'(interp_phase) - ONE_Q16);
        end
        interp_prev = x;
        if (emit) begin
            if (cur_mode == MODE_WFM) y = one_pole(deemph_acc, cur_deemph, y);
            y = one_pole(post_acc, cur_post, y);
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            audio_q = {audio_q, 16'(y)};
        end
    endtask

    // Send one I/Q beat; the predictor runs on acceptance. Drop valid after
    // the last beat of a burst, hold it when another beat follows at once.
    task automatic send_iq(input logic [7:0] ib, input logic [7:0] qb, input bit last);
        s_axis_tdata <= {qb, ib};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        predict_audio(ib, qb);
        beats_in++;
        @(negedge aclk);
        if (last) s_axis_tvalid <= 1'b0;
    endtask

    // Bursty random sender: hold valid across a burst, optional gap between bursts.
    task automatic send_random_run(input int count, input bit tone);
        int left, burst, gap;
        int ph;
        logic [7:0] ib, qb;
        left = count;
        ph = $urandom_range(0, 255);
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            for (int n = 0; n < burst && left > 0; n++) begin
                if (tone && $urandom_range(0, 9) != 0) begin
                    // rotating phasor with random phase steps, to exercise FM paths
                    ph += $urandom_range(0, 60);
                    ib = 8'(128 + ((ph % 64 < 32) ? (ph % 32) * 4 - 64 : 64 - (ph % 32) * 4));
                    qb = 8'(128 + (((ph + 16) % 64 < 32) ? ((ph + 16) % 32) * 4 - 64
                                                         : 64 - ((ph + 16) % 32) * 4));
                end else begin
                    ib = 8'($urandom_range(0, 255));
                    qb = 8'($urandom_range(0, 255));
                end
                send_iq(ib, qb, (left == 1) || (n == burst - 1 && gap != 0));
                left--;
            end
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Let the pipeline drain, then wait out any work that emits nothing.
    task automatic wait_idle();
        int guard;
        guard = 0;
        while (audio_q.size() != 0 && guard < WD_LIMIT) begin
            @(negedge aclk);
            guard++;
        end
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE: if (val[2:0] != cur_mode) begin
                cur_mode = val[2:0];
                clear_chain();
            end
            REG_RATIO:  cur_ratio = val;
            REG_PRE:    cur_pre = val[15:0];
            REG_POST:   cur_post = val[15:0];
            REG_DEEMPH: cur_deemph = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic test_extremes();
        logic [7:0] edge_vals[4] = '{8'd0, 8'd255, 8'd127, 8'd128};
        foreach (edge_vals[a]) foreach (edge_vals[b]) send_iq(edge_vals[a], edge_vals[b], 1'b0);
        send_iq(8'h55, 8'hAA, 1'b0);
        send_iq(8'hAA, 8'h55, 1'b1);
        wait_idle();
    endtask

    task automatic test_modes();
        logic [2:0] modes[8] = '{MODE_NFM, MODE_AM, MODE_USB, MODE_LSB, MODE_CW,
                                 MODE_SPARE_LO, MODE_SPARE_HI, MODE_WFM};
        write_reg(REG_RATIO, 24'h010000);
        foreach (modes[k]) begin
            write_reg(REG_MODE, 24'(modes[k]));
            write_reg(REG_MODE, 24'(modes[k]));  // same mode again: no clear
            send_iq(8'd255, 8'd255, 1'b0);  // CW overflow / largest AM value
            send_iq(8'd0, 8'd255, 1'b0);
            send_iq(8'd0, 8'd0, 1'b0);
            send_random_run(12, 1);
            wait_idle();
        end
    endtask

    task automatic test_registers();
        write_reg(REG_RATIO, 24'h000000);   // below one acts as one
        write_reg(REG_PRE, 24'hFFFF);
        write_reg(REG_POST, 24'hFFFF);
        write_reg(REG_DEEMPH, 24'hFFFF);
        write_reg(REG_SPARE_LO, 24'h123456);  // unmapped index: drop
        write_reg(REG_SPARE_HI, 24'hFFFFFF);
        send_random_run(30, 1);
        wait_idle();
        write_reg(REG_PRE, 24'h0);
        write_reg(REG_POST, 24'h0);
        write_reg(REG_DEEMPH, 24'h0);
        write_reg(REG_RATIO, 24'h018000);
        send_random_run(30, 1);
        wait_idle();
        write_reg(REG_RATIO, 24'hFFFFFF);   // huge ratio: results are rare
        send_random_run(40, 0);
        wait_idle();
    endtask

    task automatic test_random();
        logic [23:0] ratios[4] = '{24'h010000, 24'h01_8000, 24'h03_0000, 24'h2A_AAAB};
        for (int r = 0; r < 24; r++) begin
            write_reg(REG_MODE, 24'($urandom_range(0, 7)));
            write_reg(REG_RATIO, ratios[$urandom_range(0, 3)]);
            write_reg(REG_PRE, 24'($urandom_range(0, 65535)));
            write_reg(REG_POST, 24'($urandom_range(0, 65535)));
            write_reg(REG_DEEMPH, 24'($urandom_range(0, 65535)));
            send_random_run(45, $urandom_range(0, 3) != 0);
            wait_idle();
        end
    endtask

    // Receiver: stall on a duty pattern that is redrawn whenever its hold count runs out.
    initial begin
        int duty, hold;
        duty = 100; hold = 0;
        forever begin
            @(negedge aclk);
            if (hold == 0) begin
                hold = $urandom_range(10, 80);
                duty = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(10, 90);
            end
            hold--;
            m_axis_tready <= ($urandom_range(1, 100) <= duty);
        end
    end

    // Check every audio beat against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (audio_q.size() == 0) begin
                $display("%0t: unexpected audio beat, expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                if (audio_q[0] !== m_axis_tdata) begin
                    $display("%0t: audio_sample mismatch, expected %h actual %h",
                             $time, audio_q[0], m_axis_tdata);
                    errors++;
                end
                void'(audio_q.pop_front());
            end
        end
    end

    // Watchdog: advance a counter on every cycle with no beat on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("%0t: watchdog expired, %0d predictions pending", $time,
                     audio_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        predict_reset();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_extremes();
        test_modes();
        test_registers();
        test_random();
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (audio_q.size() != 0) begin
            $display("%0t: %0d predicted audio beats never arrived", $time,
                     audio_q.size());
            errors++;
        end
        $display("Covered %0d I/Q beats and %0d audio beats over all eight mode codes",
                 beats_in, beats_out);
        $display("NFM %0d WFM %0d AM %0d USB %0d LSB %0d CW %0d unused %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5], mode_hits[6] + mode_hits[7]);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

// ----- multimode_iq_demodulator.f -----
+incdir+design
design/miqd_pkg.sv
design/miqd_cordic.sv
design/multimode_iq_demodulator.sv
tb/sv/multimode_iq_demodulator_tb.sv
